>>> hdl/trapezoidal_motion_profile_macros.svh
// Assertion macros used by the checker file
`ifndef TRAPEZOIDAL_MOTION_PROFILE_MACROS_SVH
`define TRAPEZOIDAL_MOTION_PROFILE_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset
`define TMP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on clk, quiet during reset
`define TMP_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

>>> hdl/tmp_pkg.sv
`timescale 1ns / 1ps
package tmp_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL_SQ,
		ST_DIV_BRK,
		ST_MUL_DLT,
		ST_VEL,
		ST_MUL_CAP,
		ST_SQRT,
		ST_CAP,
		ST_DIV_ACC,
		ST_MUL_POS,
		ST_POS,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		FN_TICK   = 2'd0,
		FN_TARGET = 2'd1,
		FN_SYNC   = 2'd2,
		FN_NONE   = 2'd3
	} func_t;

	typedef enum logic {
		REG_SPEED = 1'b0,
		REG_ACCEL = 1'b1
	} cfg_reg_t;

	localparam logic [6:0] MUL_LAST  = 7'd32;   // 33 multiplier bits
	localparam logic [6:0] DIV_LAST  = 7'd63;   // 64 quotient bits
	localparam logic [6:0] SQRT_LAST = 7'd31;   // 32 root bits

	localparam logic [30:0] MIN_LIMIT   = 31'd167772;
	localparam logic [30:0] SPEED_RESET = 31'd16777216;
	localparam logic [30:0] ACCEL_RESET = 31'd167772160;
	localparam logic [24:0] ONE_Q24     = 25'd16777216;

	localparam logic [32:0] EPS_STOP  = 33'd17;
	localparam logic [63:0] EPS_BRAKE = 64'd1678;
	localparam logic [34:0] EPS_SNAP  = 35'd168;

endpackage

>>> hdl/trapezoidal_motion_profile.sv
`timescale 1ns / 1ps
// Trapezoidal motion reference generator in signed Q8.24. One request on the
// input stream gives one result on the output stream. A tick request (tuser 0)
// runs, from accept to result, one bit-serial shift-add multiplier pass for
// each of four products, two restoring divider passes (braking distance and
// acceleration) and a bit-pair square root, all run one after another by the
// sequencer. Set-target, re-synchronize and unused requests go from idle to
// the done state, which registers the result once the output register is free.
// The next request is taken as soon as the sequencer is back in idle, even
// while the previous result still waits on the output register. Limit registers
// are written through the cfg port; the user is to write them only between
// requests, as the block does not enforce this. Values below 167772 are
// raised to 167772.
module trapezoidal_motion_profile (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,  // measured_position, new_target, step_time, zero pad
	input  logic [1:0]  s_axis_tuser,  // func
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata,  // ref_position, ref_velocity, ref_accel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [30:0] cfg_data
);

	tmp_pkg::state_t state_q, state_d;

	logic [30:0] speed_q, accel_q;
	logic signed [31:0] held_q, prev_q, outp_q, outv_q, outa_q;
	logic synced_q;

	logic signed [31:0] p_q;
	logic [24:0] dt_q;
	logic signed [33:0] d_q;
	logic [32:0] absd_q;
	logic [63:0] mc_q, prod_q;
	logic [32:0] mp_q;
	logic [63:0] num_q;
	logic [33:0] rem_q;
	logic [32:0] den_q;
	logic [63:0] brake_q;
	logic [31:0] delta_q;
	logic signed [34:0] v_q;
	logic [63:0] x_q, r_q, bit_q;
	logic signed [31:0] acc_q;
	logic diffneg_q;
	logic [30:0] pmag_q;
	logic [6:0] cnt_q;
	logic m_tvalid_q;
	logic [95:0] m_tdata_q;

	logic accept, out_ready;
	logic signed [31:0] in_pos, in_tgt;
	logic [24:0] in_dt, dt_sat;
	tmp_pkg::func_t in_func;
	logic [63:0] prod_step;
	logic [33:0] rem_sh, rem_nx;
	logic div_ge;
	logic [63:0] quo_nx;
	logic [63:0] sq_t;
	logic sq_ge;
	logic signed [31:0] abs_prev;
	logic signed [33:0] d_nx;
	logic signed [34:0] vp, sdelta, v_mix, v_lim, v_cap, v_fin, diff;
	logic [34:0] vabs, vcap_abs, adiff;
	logic d_neg;
	logic signed [31:0] acc_val;
	logic signed [34:0] pos, pos_err, held_x;
	logic [34:0] abs_err;
	logic snap;
	logic signed [31:0] pos_sat;

	// Split the request and the handshakes
	assign s_axis_tready = (state_q == tmp_pkg::ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign in_pos        = s_axis_tdata[31:0];
	assign in_tgt        = s_axis_tdata[63:32];
	assign in_dt         = s_axis_tdata[88:64];
	assign in_func       = tmp_pkg::func_t'(s_axis_tuser);
	assign dt_sat        = (in_dt > tmp_pkg::ONE_Q24) ? tmp_pkg::ONE_Q24 : in_dt;
	assign out_ready     = !m_tvalid_q || m_axis_tready;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;

	// Serial step of the shift-add multiplier, divider and square root
	assign prod_step = prod_q + (mp_q[0] ? mc_q : 64'd0);
	assign rem_sh    = {rem_q[32:0], num_q[63]};
	assign div_ge    = (rem_sh >= {1'b0, den_q});
	assign rem_nx    = div_ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
	assign quo_nx    = {num_q[62:0], div_ge};
	assign sq_t      = r_q + bit_q;
	assign sq_ge     = (x_q >= sq_t);

	// Distance to target and magnitude of the previous velocity
	assign abs_prev = (prev_q < 0) ? -prev_q : prev_q;
	assign d_nx     = {{2{held_q[31]}}, held_q} - {{2{p_q[31]}}, p_q};
	assign d_neg    = d_q[33];

	// Stop near the target, accelerate, brake or reverse, then clamp to the speed limit
	always_comb begin
		vp     = {{3{prev_q[31]}}, prev_q};
		sdelta = d_neg ? -$signed({3'b0, delta_q}) : $signed({3'b0, delta_q});
		if (absd_q <= tmp_pkg::EPS_STOP) begin
			v_mix = '0;
		end else if ((prev_q < 0 && !d_neg) || (prev_q > 0 && d_neg)) begin
			v_mix = vp + sdelta;
		end else if ({31'b0, absd_q} > brake_q + tmp_pkg::EPS_BRAKE) begin
			v_mix = vp + sdelta;
		end else begin
			v_mix = vp - sdelta;
		end
		v_lim = v_mix;
		if (v_mix > $signed({4'b0, speed_q})) v_lim = $signed({4'b0, speed_q});
		if (v_mix < -$signed({4'b0, speed_q})) v_lim = -$signed({4'b0, speed_q});
	end

	// Cap at the stopping speed, zero tiny speeds, form the velocity change
	always_comb begin
		vabs = (v_q < 0) ? 35'(-v_q) : 35'(v_q);
		if ({29'b0, vabs} > r_q) begin
			v_cap = d_neg ? -$signed({3'b0, r_q[31:0]}) : $signed({3'b0, r_q[31:0]});
		end else begin
			v_cap = v_q;
		end
		v_fin = (v_cap > -35'sd17 && v_cap < 35'sd17) ? 35'sd0 : v_cap;
		vcap_abs = (v_fin < 0) ? 35'(-v_fin) : 35'(v_fin);
		diff  = v_fin - {{3{prev_q[31]}}, prev_q};
		adiff = (diff < 0) ? 35'(-diff) : 35'(diff);
	end

	// Saturate the acceleration quotient, zero when the step time is zero
	always_comb begin
		if (dt_q == 25'd0) begin
			acc_val = '0;
		end else if (diffneg_q) begin
			acc_val = (quo_nx > 64'h80000000) ? 32'sh80000000 : -$signed(quo_nx[31:0]);
		end else begin
			acc_val = (quo_nx > 64'h7fffffff) ? 32'sh7fffffff : $signed(quo_nx[31:0]);
		end
	end

	// Advance the position, snap on arrival or overshoot, saturate
	always_comb begin
		held_x  = {{3{held_q[31]}}, held_q};
		pos     = (v_q < 0) ? ({{3{p_q[31]}}, p_q} - $signed({4'b0, pmag_q}))
		                    : ({{3{p_q[31]}}, p_q} + $signed({4'b0, pmag_q}));
		pos_err = held_x - pos;
		abs_err = (pos_err < 0) ? 35'(-pos_err) : 35'(pos_err);
		snap    = (abs_err <= tmp_pkg::EPS_SNAP) ||
		          (d_q > 0 && pos >= held_x) || (d_q < 0 && pos <= held_x);
		if (pos > 35'sh7fffffff) begin
			pos_sat = 32'sh7fffffff;
		end else if (pos < -35'sh80000000) begin
			pos_sat = 32'sh80000000;
		end else begin
			pos_sat = pos[31:0];
		end
	end

	// Hold the sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= tmp_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	// Advance through the tick passes; other requests go straight to done
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tmp_pkg::ST_IDLE: begin
				if (accept) state_d = (in_func == tmp_pkg::FN_TICK) ? tmp_pkg::ST_PREP
				                                                    : tmp_pkg::ST_DONE;
			end
			tmp_pkg::ST_PREP:    state_d = tmp_pkg::ST_MUL_SQ;
			tmp_pkg::ST_MUL_SQ:  if (cnt_q == tmp_pkg::MUL_LAST) state_d = tmp_pkg::ST_DIV_BRK;
			tmp_pkg::ST_DIV_BRK: if (cnt_q == tmp_pkg::DIV_LAST) state_d = tmp_pkg::ST_MUL_DLT;
			tmp_pkg::ST_MUL_DLT: if (cnt_q == tmp_pkg::MUL_LAST) state_d = tmp_pkg::ST_VEL;
			tmp_pkg::ST_VEL:     state_d = tmp_pkg::ST_MUL_CAP;
			tmp_pkg::ST_MUL_CAP: if (cnt_q == tmp_pkg::MUL_LAST) state_d = tmp_pkg::ST_SQRT;
			tmp_pkg::ST_SQRT:    if (cnt_q == tmp_pkg::SQRT_LAST) state_d = tmp_pkg::ST_CAP;
			tmp_pkg::ST_CAP:     state_d = tmp_pkg::ST_DIV_ACC;
			tmp_pkg::ST_DIV_ACC: if (cnt_q == tmp_pkg::DIV_LAST) state_d = tmp_pkg::ST_MUL_POS;
			tmp_pkg::ST_MUL_POS: if (cnt_q == tmp_pkg::MUL_LAST) state_d = tmp_pkg::ST_POS;
			tmp_pkg::ST_POS:     state_d = tmp_pkg::ST_DONE;
			tmp_pkg::ST_DONE:    if (out_ready) state_d = tmp_pkg::ST_IDLE;
			default:             state_d = tmp_pkg::ST_IDLE;
		endcase
	end

	// Hold the limits, the motion state and the output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q    <= tmp_pkg::SPEED_RESET;
			accel_q    <= tmp_pkg::ACCEL_RESET;
			held_q     <= '0;
			prev_q     <= '0;
			synced_q   <= 1'b0;
			outp_q     <= '0;
			outv_q     <= '0;
			outa_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (tmp_pkg::cfg_reg_t'(cfg_index))
					tmp_pkg::REG_SPEED: speed_q <= (cfg_data < tmp_pkg::MIN_LIMIT) ?
					                               tmp_pkg::MIN_LIMIT : cfg_data;
					tmp_pkg::REG_ACCEL: accel_q <= (cfg_data < tmp_pkg::MIN_LIMIT) ?
					                               tmp_pkg::MIN_LIMIT : cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				if (in_func == tmp_pkg::FN_TARGET) begin
					held_q <= in_tgt;
				end else if (in_func == tmp_pkg::FN_SYNC ||
				             (in_func == tmp_pkg::FN_TICK && !synced_q)) begin
					held_q   <= in_pos;
					prev_q   <= '0;
					synced_q <= 1'b1;
					outp_q   <= in_pos;
					outv_q   <= '0;
					outa_q   <= '0;
				end
			end
			if (state_q == tmp_pkg::ST_POS) begin
				if (snap) begin
					outp_q <= held_q;
					outv_q <= '0;
					outa_q <= '0;
					prev_q <= '0;
				end else begin
					outp_q <= pos_sat;
					outv_q <= v_q[31:0];
					outa_q <= acc_q;
					prev_q <= v_q[31:0];
				end
			end
			if (state_q == tmp_pkg::ST_DONE && out_ready) m_tvalid_q <= 1'b1;
			else if (m_axis_tready)                        m_tvalid_q <= 1'b0;
		end
	end

	// Run the serial datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			p_q  <= in_pos;
			dt_q <= dt_sat;
		end
		case (state_q)
			tmp_pkg::ST_PREP: begin
				cnt_q  <= '0;
				d_q    <= d_nx;
				absd_q <= d_nx[33] ? 33'(-d_nx) : 33'(d_nx);
				mc_q   <= {32'b0, abs_prev};
				mp_q   <= {1'b0, abs_prev};
				prod_q <= '0;
			end
			tmp_pkg::ST_MUL_SQ, tmp_pkg::ST_MUL_DLT, tmp_pkg::ST_MUL_CAP,
			tmp_pkg::ST_MUL_POS: begin
				prod_q <= prod_step;
				mc_q   <= {mc_q[62:0], 1'b0};
				mp_q   <= {1'b0, mp_q[32:1]};
				if (cnt_q == tmp_pkg::MUL_LAST) begin
					cnt_q <= '0;
					if (state_q == tmp_pkg::ST_MUL_SQ) begin
						num_q <= prod_step;
						rem_q <= '0;
						den_q <= {1'b0, accel_q, 1'b0};
					end
					if (state_q == tmp_pkg::ST_MUL_DLT) delta_q <= prod_step[55:24];
					if (state_q == tmp_pkg::ST_MUL_CAP) begin
						x_q   <= prod_step;
						r_q   <= '0;
						bit_q <= 64'h4000000000000000;
					end
					if (state_q == tmp_pkg::ST_MUL_POS) pmag_q <= prod_step[54:24];
				end else begin
					cnt_q <= cnt_q + 7'd1;
				end
			end
			tmp_pkg::ST_DIV_BRK, tmp_pkg::ST_DIV_ACC: begin
				rem_q <= rem_nx;
				num_q <= quo_nx;
				if (cnt_q == tmp_pkg::DIV_LAST) begin
					cnt_q  <= '0;
					mp_q   <= {8'b0, dt_q};
					prod_q <= '0;
					if (state_q == tmp_pkg::ST_DIV_BRK) begin
						brake_q <= quo_nx;
						mc_q    <= {33'b0, accel_q};
					end else begin
						acc_q <= acc_val;
						mc_q  <= {33'b0, vabs[30:0]};
					end
				end else begin
					cnt_q <= cnt_q + 7'd1;
				end
			end
			tmp_pkg::ST_VEL: begin
				cnt_q  <= '0;
				v_q    <= v_lim;
				mc_q   <= {32'b0, accel_q, 1'b0};
				mp_q   <= absd_q;
				prod_q <= '0;
			end
			tmp_pkg::ST_SQRT: begin
				if (sq_ge) begin
					x_q <= x_q - sq_t;
					r_q <= {1'b0, r_q[63:1]} + bit_q;
				end else begin
					r_q <= {1'b0, r_q[63:1]};
				end
				bit_q <= {2'b0, bit_q[63:2]};
				cnt_q <= (cnt_q == tmp_pkg::SQRT_LAST) ? 7'd0 : cnt_q + 7'd1;
			end
			tmp_pkg::ST_CAP: begin
				cnt_q     <= '0;
				v_q       <= v_fin;
				diffneg_q <= diff[34];
				num_q     <= {7'b0, adiff[32:0], 24'b0};
				rem_q     <= '0;
				den_q     <= {8'b0, dt_q};
				mc_q      <= {29'b0, vcap_abs};
			end
			tmp_pkg::ST_DONE: begin
				cnt_q <= '0;
				if (out_ready) m_tdata_q <= {outa_q, outv_q, outp_q};
			end
			default: cnt_q <= '0;
		endcase
	end

endmodule

>>> hdl/tmp_checker.sv
`timescale 1ns / 1ps
`include "trapezoidal_motion_profile_macros.svh"
module tmp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [95:0] m_axis_tdata,
	input logic        cfg_ready
);

	// Hold a stalled result
	`TMP_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

	// Take one request at a time
	`TMP_ASSERT_NXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)

	// Return to idle when a new result is shown
	`TMP_ASSERT_IMP(a_idle_on_result, $rose(m_axis_tvalid), s_axis_tready)

	// Never drop a limit write
	`TMP_ASSERT_IMP(a_cfg_open, 1'b1, cfg_ready)

endmodule

bind trapezoidal_motion_profile tmp_checker u_tmp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.cfg_ready     (cfg_ready)
);
